@@ sv/tcwseg_pkg.sv @@
// ----------------------------------------------------------------------------
// tcwseg_pkg
// Shared types and constants of the congestion window segmenter: item
// layouts, operation codes, register map and shared adder interface.
// ----------------------------------------------------------------------------
package tcwseg_pkg;

    localparam int SEQ_W = 32;
    localparam int WIN_W = 20;
    localparam int OFF_W = 16;
    localparam int LEN_W = 11;
    localparam int OP_W  = 2;

    localparam logic [WIN_W-1:0] WIN_MAX = 20'hFFFFF;

    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
    localparam logic [OP_W-1:0] OP_SEND    = 2'd3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_INIT_SEQ  = 1'b0;
    localparam logic REG_WIN_LIMIT = 1'b1;

    localparam logic [SEQ_W-1:0] INIT_SEQ_RESET  = 32'd1234;
    localparam logic [OFF_W-1:0] WIN_LIMIT_RESET = 16'd8192;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SEQ_W-1:0] ack_number;
        logic [OFF_W-1:0] buffered_bytes;
        logic [OFF_W-1:0] recv_window;
    } in_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0] segment_seq;
        logic [LEN_W-1:0] segment_length;
        logic [OFF_W-1:0] buffer_offset;
        logic [WIN_W-1:0] congestion_window;
        logic [WIN_W-1:0] slow_start_threshold;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0] initial_sequence;
        logic [OFF_W-1:0] window_limit;
    } cfg_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [SEQ_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

endpackage

@@ sv/tcwseg_stream_if.sv @@
// ----------------------------------------------------------------------------
// tcwseg_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface tcwseg_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

@@ sv/tcwseg_alu.sv @@
// ----------------------------------------------------------------------------
// tcwseg_alu
// Shared 32-bit add/subtract unit with carry or borrow out.
// ----------------------------------------------------------------------------
module tcwseg_alu (
    input  tcwseg_pkg::alu_req_t req,
    output tcwseg_pkg::alu_rsp_t rsp
);

    logic [tcwseg_pkg::SEQ_W:0] full;

    always_comb
    begin
        unique case (req.op)
            tcwseg_pkg::ALU_ADD: full = {1'b0, req.a} + {1'b0, req.b};
            tcwseg_pkg::ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
            default:             full = '0;
        endcase
    end

    assign rsp.sum   = full[tcwseg_pkg::SEQ_W-1:0];
    assign rsp.carry = full[tcwseg_pkg::SEQ_W];

endmodule

@@ sv/tcwseg_core.sv @@
// ----------------------------------------------------------------------------
// tcwseg_core
// Sequencer holding the connection state; the window and sequence adds,
// subtracts and compares, including the serial window division, share one unit.
// ----------------------------------------------------------------------------
module tcwseg_core #(
    parameter int SEGMENT_SIZE = 1024,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcwseg_pkg::in_item_t  in_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output tcwseg_pkg::out_item_t res_item,
    input  tcwseg_pkg::cfg_t      cfg
);

    localparam int SQ      = SEGMENT_SIZE * SEGMENT_SIZE;
    localparam int QW      = $clog2(SQ + 1);
    localparam int QCNT_W  = $clog2(QW);
    localparam int SLEN_W  = $clog2(SEGMENT_SIZE + 1);
    localparam int NSEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int WIN_W   = tcwseg_pkg::WIN_W;
    localparam int SEQ_W   = tcwseg_pkg::SEQ_W;
    localparam int OFF_W   = tcwseg_pkg::OFF_W;

    localparam logic [WIN_W-1:0]  CW_START  = WIN_W'(SEGMENT_SIZE);
    localparam logic [WIN_W-1:0]  THR_START = WIN_W'(64 * SEGMENT_SIZE);
    localparam logic [SEQ_W-1:0]  SEG_WORD  = SEQ_W'(SEGMENT_SIZE);
    localparam logic [SEQ_W-1:0]  DUP_STEP  = SEQ_W'(3 * SEGMENT_SIZE);
    localparam logic [SLEN_W-1:0] SEG_LEN   = SLEN_W'(SEGMENT_SIZE);
    localparam logic [QW-1:0]     SQ_WORD   = QW'(SQ);
    localparam logic [QW-1:0]     SEG_Q     = QW'(SEGMENT_SIZE);
    localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(QW - 1);
    localparam logic [NSEG_W-1:0] NSEG_MAX  = NSEG_W'(MAX_SEGMENTS);
    localparam logic [SEQ_W-1:0]  MARK_START =
        tcwseg_pkg::INIT_SEQ_RESET - 32'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_ACK_EQ,
        S_DUP_ADD,
        S_ACK_D,
        S_ACK_FL,
        S_ACK_CMP,
        S_ACK_THR,
        S_DIV,
        S_GROW,
        S_SND_FL,
        S_SND_UNS,
        S_LEN_SEG,
        S_WL_ROOM,
        S_WL_MIN,
        S_CW_ROOM,
        S_CW_MIN,
        S_RW_ROOM,
        S_RW_MIN,
        S_CHECK,
        S_CAPTURE,
        S_UPD_SENT,
        S_UPD_W,
        S_UPD_UNS,
        S_STAT_FL,
        S_STAT_SEQ,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [SEQ_W-1:0]      ack_reg;
    logic [OFF_W-1:0]      buf_reg;
    logic [OFF_W-1:0]      rwnd_reg;
    logic [WIN_W-1:0]      cw_reg;
    logic [WIN_W-1:0]      thr_reg;
    logic [SEQ_W-1:0]      rack_reg;
    logic [SEQ_W-1:0]      sent_reg;
    logic [SEQ_W-1:0]      acked_reg;
    logic [1:0]            dup_reg;
    logic [SEQ_W-1:0]      w_reg;
    logic [SEQ_W-1:0]      tmp_reg;
    logic [OFF_W-1:0]      unsent_reg;
    logic [SLEN_W-1:0]     len_reg;
    logic [WIN_W-1:0]      rem_reg;
    logic [QW-1:0]         q_reg;
    logic [QCNT_W-1:0]     qcnt_reg;
    logic [NSEG_W-1:0]     nseg_reg;
    logic [SEQ_W-1:0]      pend_seq_reg;
    logic [SLEN_W-1:0]     pend_len_reg;
    logic [OFF_W-1:0]      pend_off_reg;
    logic                  last_reg;
    logic                  has_pend_reg;

    tcwseg_pkg::alu_req_t  alu_req;
    tcwseg_pkg::alu_rsp_t  alu_rsp;

    logic [SEQ_W-1:0]      len_word;
    logic [SEQ_W-1:0]      room;
    logic [WIN_W-1:0]      sat_sum;
    logic [1:0]            dup_inc;

    tcwseg_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign len_word = {{(SEQ_W-SLEN_W){1'b0}}, len_reg};
    assign room     = alu_rsp.carry ? '0 : alu_rsp.sum;
    assign sat_sum  = (alu_rsp.sum[SEQ_W-1:WIN_W] != '0) ? tcwseg_pkg::WIN_MAX
                                                        : alu_rsp.sum[WIN_W-1:0];
    assign dup_inc  = dup_reg + 2'd1;

    always_comb
    begin
        alu_req.op = tcwseg_pkg::ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            S_INIT:
            begin
                alu_req.a = cfg.initial_sequence;
                alu_req.b = 32'd1;
            end
            S_ACK_EQ:
            begin
                alu_req.a = ack_reg;
                alu_req.b = rack_reg;
            end
            S_DUP_ADD:
            begin
                alu_req.op = tcwseg_pkg::ALU_ADD;
                alu_req.a  = {{(SEQ_W-WIN_W){1'b0}}, thr_reg};
                alu_req.b  = DUP_STEP;
            end
            S_ACK_D:
            begin
                alu_req.a = ack_reg;
                alu_req.b = acked_reg;
            end
            S_ACK_FL, S_SND_FL, S_STAT_FL:
            begin
                alu_req.a = sent_reg;
                alu_req.b = acked_reg;
            end
            S_ACK_CMP:
            begin
                alu_req.a = w_reg;
                alu_req.b = tmp_reg;
            end
            S_ACK_THR:
            begin
                alu_req.a = {{(SEQ_W-WIN_W){1'b0}}, cw_reg};
                alu_req.b = {{(SEQ_W-WIN_W){1'b0}}, thr_reg};
            end
            S_DIV:
            begin
                alu_req.a = {{(SEQ_W-WIN_W-1){1'b0}}, rem_reg, q_reg[QW-1]};
                alu_req.b = {{(SEQ_W-WIN_W){1'b0}}, cw_reg};
            end
            S_GROW:
            begin
                alu_req.op = tcwseg_pkg::ALU_ADD;
                alu_req.a  = {{(SEQ_W-WIN_W){1'b0}}, cw_reg};
                alu_req.b  = {{(SEQ_W-QW){1'b0}}, q_reg};
            end
            S_SND_UNS:
            begin
                alu_req.a = {{(SEQ_W-OFF_W){1'b0}}, buf_reg};
                alu_req.b = w_reg;
            end
            S_LEN_SEG:
            begin
                alu_req.a = {{(SEQ_W-OFF_W){1'b0}}, unsent_reg};
                alu_req.b = SEG_WORD;
            end
            S_WL_ROOM:
            begin
                alu_req.a = {{(SEQ_W-OFF_W){1'b0}}, cfg.window_limit};
                alu_req.b = w_reg;
            end
            S_CW_ROOM:
            begin
                alu_req.a = {{(SEQ_W-WIN_W){1'b0}}, cw_reg};
                alu_req.b = w_reg;
            end
            S_RW_ROOM:
            begin
                alu_req.a = {{(SEQ_W-OFF_W){1'b0}}, rwnd_reg};
                alu_req.b = w_reg;
            end
            S_WL_MIN, S_CW_MIN, S_RW_MIN:
            begin
                alu_req.a = len_word;
                alu_req.b = tmp_reg;
            end
            S_CAPTURE, S_STAT_SEQ:
            begin
                alu_req.op = tcwseg_pkg::ALU_ADD;
                alu_req.a  = sent_reg;
                alu_req.b  = 32'd1;
            end
            S_UPD_SENT:
            begin
                alu_req.op = tcwseg_pkg::ALU_ADD;
                alu_req.a  = sent_reg;
                alu_req.b  = len_word;
            end
            S_UPD_W:
            begin
                alu_req.op = tcwseg_pkg::ALU_ADD;
                alu_req.a  = w_reg;
                alu_req.b  = len_word;
            end
            S_UPD_UNS:
            begin
                alu_req.a = {{(SEQ_W-OFF_W){1'b0}}, unsent_reg};
                alu_req.b = len_word;
            end
            default:
            begin
                alu_req.op = tcwseg_pkg::ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ack_reg      <= '0;
            buf_reg      <= '0;
            rwnd_reg     <= '0;
            cw_reg       <= CW_START;
            thr_reg      <= THR_START;
            rack_reg     <= MARK_START;
            sent_reg     <= MARK_START;
            acked_reg    <= MARK_START;
            dup_reg      <= '0;
            w_reg        <= '0;
            tmp_reg      <= '0;
            unsent_reg   <= '0;
            len_reg      <= '0;
            rem_reg      <= '0;
            q_reg        <= '0;
            qcnt_reg     <= '0;
            nseg_reg     <= '0;
            pend_seq_reg <= '0;
            pend_len_reg <= '0;
            pend_off_reg <= '0;
            last_reg     <= 1'b0;
            has_pend_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ack_reg  <= in_item.ack_number;
                        buf_reg  <= in_item.buffered_bytes;
                        rwnd_reg <= in_item.recv_window;
                        case (in_item.operation)
                            tcwseg_pkg::OP_INIT:
                            begin
                                cw_reg    <= CW_START;
                                thr_reg   <= THR_START;
                                dup_reg   <= '0;
                                state_reg <= S_INIT;
                            end
                            tcwseg_pkg::OP_ACK:
                            begin
                                state_reg <= S_ACK_EQ;
                            end
                            tcwseg_pkg::OP_TIMEOUT:
                            begin
                                thr_reg   <= {1'b0, cw_reg[WIN_W-1:1]};
                                cw_reg    <= CW_START;
                                rack_reg  <= acked_reg;
                                sent_reg  <= acked_reg;
                                dup_reg   <= '0;
                                state_reg <= S_STAT_FL;
                            end
                            default:
                            begin
                                state_reg <= S_SND_FL;
                            end
                        endcase
                    end
                end
                S_INIT:
                begin
                    sent_reg  <= alu_rsp.sum;
                    acked_reg <= alu_rsp.sum;
                    rack_reg  <= alu_rsp.sum;
                    state_reg <= S_STAT_FL;
                end
                S_ACK_EQ:
                begin
                    if (alu_rsp.sum == '0)
                    begin
                        if (dup_inc == 2'd3)
                        begin
                            thr_reg   <= {1'b0, cw_reg[WIN_W-1:1]};
                            rack_reg  <= acked_reg;
                            dup_reg   <= '0;
                            state_reg <= S_DUP_ADD;
                        end
                        else
                        begin
                            dup_reg   <= dup_inc;
                            state_reg <= S_STAT_FL;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ACK_D;
                    end
                end
                S_DUP_ADD:
                begin
                    cw_reg    <= sat_sum;
                    state_reg <= S_STAT_FL;
                end
                S_ACK_D:
                begin
                    tmp_reg   <= alu_rsp.sum;
                    state_reg <= S_ACK_FL;
                end
                S_ACK_FL:
                begin
                    w_reg     <= alu_rsp.sum;
                    state_reg <= S_ACK_CMP;
                end
                S_ACK_CMP:
                begin
                    if (tmp_reg != '0 && !alu_rsp.carry)
                        state_reg <= S_ACK_THR;
                    else
                        state_reg <= S_STAT_FL;
                end
                S_ACK_THR:
                begin
                    if (alu_rsp.carry || cw_reg == '0)
                    begin
                        q_reg     <= SEG_Q;
                        state_reg <= S_GROW;
                    end
                    else
                    begin
                        q_reg     <= SQ_WORD;
                        rem_reg   <= '0;
                        qcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (alu_rsp.carry)
                        rem_reg <= {rem_reg[WIN_W-2:0], q_reg[QW-1]};
                    else
                        rem_reg <= alu_rsp.sum[WIN_W-1:0];
                    q_reg    <= {q_reg[QW-2:0], !alu_rsp.carry};
                    qcnt_reg <= qcnt_reg + QCNT_W'(1);
                    if (qcnt_reg == QCNT_LAST)
                        state_reg <= S_GROW;
                end
                S_GROW:
                begin
                    cw_reg    <= sat_sum;
                    acked_reg <= ack_reg;
                    rack_reg  <= ack_reg;
                    dup_reg   <= '0;
                    state_reg <= S_STAT_FL;
                end
                S_SND_FL:
                begin
                    w_reg     <= alu_rsp.sum;
                    state_reg <= S_SND_UNS;
                end
                S_SND_UNS:
                begin
                    unsent_reg   <= room[OFF_W-1:0];
                    nseg_reg     <= '0;
                    has_pend_reg <= 1'b0;
                    state_reg    <= S_LEN_SEG;
                end
                S_LEN_SEG:
                begin
                    if (alu_rsp.carry)
                        len_reg <= unsent_reg[SLEN_W-1:0];
                    else
                        len_reg <= SEG_LEN;
                    state_reg <= S_WL_ROOM;
                end
                S_WL_ROOM, S_CW_ROOM, S_RW_ROOM:
                begin
                    tmp_reg <= room;
                    unique case (state_reg)
                        S_WL_ROOM: state_reg <= S_WL_MIN;
                        S_CW_ROOM: state_reg <= S_CW_MIN;
                        default:   state_reg <= S_RW_MIN;
                    endcase
                end
                S_WL_MIN, S_CW_MIN, S_RW_MIN:
                begin
                    if (!alu_rsp.carry)
                        len_reg <= tmp_reg[SLEN_W-1:0];
                    unique case (state_reg)
                        S_WL_MIN: state_reg <= S_CW_ROOM;
                        S_CW_MIN: state_reg <= S_RW_ROOM;
                        default:  state_reg <= S_CHECK;
                    endcase
                end
                S_CHECK:
                begin
                    if (len_reg == '0)
                    begin
                        if (has_pend_reg)
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_STAT_FL;
                        end
                    end
                    else if (has_pend_reg)
                    begin
                        last_reg  <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_CAPTURE;
                    end
                end
                S_CAPTURE:
                begin
                    pend_seq_reg <= alu_rsp.sum;
                    pend_len_reg <= len_reg;
                    pend_off_reg <= w_reg[OFF_W-1:0];
                    has_pend_reg <= 1'b1;
                    nseg_reg     <= nseg_reg + NSEG_W'(1);
                    state_reg    <= S_UPD_SENT;
                end
                S_UPD_SENT:
                begin
                    sent_reg  <= alu_rsp.sum;
                    state_reg <= S_UPD_W;
                end
                S_UPD_W:
                begin
                    w_reg     <= alu_rsp.sum;
                    state_reg <= S_UPD_UNS;
                end
                S_UPD_UNS:
                begin
                    unsent_reg <= alu_rsp.sum[OFF_W-1:0];
                    if (nseg_reg == NSEG_MAX)
                    begin
                        last_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_LEN_SEG;
                    end
                end
                S_STAT_FL:
                begin
                    pend_off_reg <= alu_rsp.sum[OFF_W-1:0];
                    pend_len_reg <= '0;
                    state_reg    <= S_STAT_SEQ;
                end
                S_STAT_SEQ:
                begin
                    pend_seq_reg <= alu_rsp.sum;
                    last_reg     <= 1'b1;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (res_ready)
                    begin
                        if (last_reg)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_CAPTURE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);

    assign res_item.segment_seq          = pend_seq_reg;
    assign res_item.segment_length       = tcwseg_pkg::LEN_W'(pend_len_reg);
    assign res_item.buffer_offset        = pend_off_reg;
    assign res_item.congestion_window    = cw_reg;
    assign res_item.slow_start_threshold = thr_reg;
    assign res_item.last                 = last_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("core idle right after taking a word");

    a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cw_reg != '0)
        else $error("congestion window reached zero");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pend_len_reg <= SEG_LEN))
        else $error("segment longer than segment size");

    a_nseg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nseg_reg <= NSEG_MAX)
        else $error("segment count beyond limit");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && last_reg) |=> (state_reg == S_IDLE))
        else $error("final word did not end the item");
`endif

endmodule

@@ sv/tcp_congestion_window_segmenter.sv @@
// ----------------------------------------------------------------------------
// tcp_congestion_window_segmenter
// Reno-style congestion window and go-back-N segmenting for one connection.
// ----------------------------------------------------------------------------
// in_ch takes one word per operation: init, ack, timeout or send request.
// out_ch gives one or more words per operation; last marks the final one.
// Init, ack, timeout and a send that emits nothing give a single status word
// with segment_length 0. A send gives one word per segment, at most
// MAX_SEGMENTS of them.
// The window and sequence arithmetic runs through one shared 32-bit
// add/subtract unit under a sequencer, and in_ch is not ready until the last
// word of the current operation has been handed to the output register.
// An ack in congestion avoidance runs a serial window division of QW steps,
// where QW is the bit width of SEGMENT_SIZE squared (21 at the default).
// The output register holds one word; when out_ch stalls the sequencer
// waits in place and no word is lost.
// The APB port sets initial_sequence (0x0) and window_limit (0x4); write it
// only while the block is idle. Reset restores both registers and the
// connection state as after an init with initial_sequence 1234.
// ----------------------------------------------------------------------------
module tcp_congestion_window_segmenter #(
    parameter int SEGMENT_SIZE = 1024,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tcwseg_stream_if.sink                      in_ch,
    tcwseg_stream_if.source                    out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcwseg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcwseg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcwseg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);

    tcwseg_pkg::cfg_t      cfg_reg;
    tcwseg_pkg::out_item_t out_item_reg;
    logic                  out_valid_reg;

    tcwseg_pkg::in_item_t  core_in;
    tcwseg_pkg::out_item_t res_item;
    logic                  res_valid;
    logic                  res_ready;
    logic                  core_ready;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_sequence <= tcwseg_pkg::INIT_SEQ_RESET;
            cfg_reg.window_limit     <= tcwseg_pkg::WIN_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                tcwseg_pkg::REG_INIT_SEQ:  cfg_reg.initial_sequence <= pwdata;
                tcwseg_pkg::REG_WIN_LIMIT: cfg_reg.window_limit <= pwdata[15:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            tcwseg_pkg::REG_INIT_SEQ:  prdata = cfg_reg.initial_sequence;
            tcwseg_pkg::REG_WIN_LIMIT: prdata = {16'b0, cfg_reg.window_limit};
            default:                   prdata = '0;
        endcase
    end

    assign core_in.operation      = in_ch.payload.operation;
    assign core_in.ack_number     = in_ch.payload.ack_number;
    assign core_in.buffered_bytes = in_ch.payload.buffered_bytes;
    assign core_in.recv_window    = in_ch.payload.recv_window;
    assign in_ch.ready            = core_ready;

    tcwseg_core #(
        .SEGMENT_SIZE (SEGMENT_SIZE),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (core_ready),
        .in_item   (core_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg       (cfg_reg)
    );

    // output word register
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
                out_item_reg <= res_item;
        end
    end

    assign out_ch.valid                        = out_valid_reg;
    assign out_ch.payload.segment_seq          = out_item_reg.segment_seq;
    assign out_ch.payload.segment_length       = out_item_reg.segment_length;
    assign out_ch.payload.buffer_offset        = out_item_reg.buffer_offset;
    assign out_ch.payload.congestion_window    = out_item_reg.congestion_window;
    assign out_ch.payload.slow_start_threshold = out_item_reg.slow_start_threshold;
    assign out_ch.payload.last                 = out_item_reg.last;

endmodule

@@ dv/tcwseg_checker.sv @@
// ----------------------------------------------------------------------------
// tcwseg_checker
// Scoreboard for the congestion window segmenter. Tracks the register writes
// on the APB port, keeps its own copy of the connection state, works out the
// words each accepted operation must produce and compares every output word
// against the oldest one still due.
// ----------------------------------------------------------------------------
module tcwseg_checker #(
    parameter int SEGMENT_SIZE = 1024,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  tcwseg_pkg::in_item_t              in_word,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  tcwseg_pkg::out_item_t             out_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [tcwseg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcwseg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcwseg_pkg::SEQ_W-1:0]      sent_upto,
    output logic [tcwseg_pkg::SEQ_W-1:0]      acked_upto,
    output int                                due_count,
    output int                                fail_count,
    output int                                op_count,
    output int                                word_count,
    output int                                longest_burst,
    output int                                recoveries,
    output int                                timeouts
);

    localparam int SEQ_W = tcwseg_pkg::SEQ_W;
    localparam int WIN_W = tcwseg_pkg::WIN_W;
    localparam int OFF_W = tcwseg_pkg::OFF_W;
    localparam int LEN_W = tcwseg_pkg::LEN_W;
    localparam logic [WIN_W-1:0] WIN_MAX = tcwseg_pkg::WIN_MAX;

    logic [SEQ_W-1:0]      init_seq;
    logic [OFF_W-1:0]      win_limit;
    logic [WIN_W-1:0]      cwnd;
    logic [WIN_W-1:0]      ssthresh;
    logic [SEQ_W-1:0]      rec_ack;
    logic [SEQ_W-1:0]      snd_mark;
    logic [SEQ_W-1:0]      ack_mark;
    logic [1:0]            dups;
    tcwseg_pkg::out_item_t due_words[$];
    int                    fails;
    int                    ops;
    int                    words;
    int                    burst_max;
    int                    halvings;
    int                    rewinds;

    function automatic logic [WIN_W-1:0] win_add(input logic [WIN_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] sum;
        sum = {13'd0, a} + {1'b0, b};
        return (sum > {13'd0, WIN_MAX}) ? WIN_MAX : sum[WIN_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] headroom(input logic [SEQ_W-1:0] lim,
                                                  input logic [SEQ_W-1:0] used);
        return (lim > used) ? lim - used : '0;
    endfunction

    function automatic logic [SEQ_W-1:0] smaller(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic tcwseg_pkg::out_item_t make_word(input logic [SEQ_W-1:0] seq,
                                                        input logic [SEQ_W-1:0] len,
                                                        input logic [SEQ_W-1:0] off,
                                                        input logic             lst);
        tcwseg_pkg::out_item_t r;
        r.segment_seq          = seq;
        r.segment_length       = len[LEN_W-1:0];
        r.buffer_offset        = off[OFF_W-1:0];
        r.congestion_window    = cwnd;
        r.slow_start_threshold = ssthresh;
        r.last                 = lst;
        return r;
    endfunction

    task automatic restart();
        cwnd     = WIN_W'(SEGMENT_SIZE);
        ssthresh = WIN_W'(64 * SEGMENT_SIZE);
        snd_mark = init_seq - SEQ_W'(1);
        ack_mark = init_seq - SEQ_W'(1);
        rec_ack  = ack_mark;
        dups     = '0;
    endtask

    task automatic report(input string what, input logic [SEQ_W-1:0] got,
                          input logic [SEQ_W-1:0] want);
        $display("mismatch at word %0d, %s: got 0x%0h, expected 0x%0h",
                 words, what, got, want);
        fails++;
    endtask

    task automatic enqueue(input tcwseg_pkg::out_item_t w);
        due_words = {due_words, w};
    endtask

    task automatic advance_connection(input tcwseg_pkg::in_item_t w);
        logic [SEQ_W-1:0]      flight;
        logic [SEQ_W-1:0]      d;
        logic [SEQ_W-1:0]      used;
        logic [SEQ_W-1:0]      len;
        logic [SEQ_W-1:0]      unsent;
        tcwseg_pkg::out_item_t held;
        int                    n;
        n = 0;
        ops++;
        case (w.operation)
            tcwseg_pkg::OP_INIT:
            begin
                restart();
            end
            tcwseg_pkg::OP_ACK:
            begin
                flight = snd_mark - ack_mark;
                d      = w.ack_number - ack_mark;
                if (w.ack_number == rec_ack)
                begin
                    dups = dups + 2'd1;
                    if (dups == 2'd3)
                    begin
                        ssthresh = cwnd >> 1;
                        cwnd     = win_add(ssthresh, SEQ_W'(3 * SEGMENT_SIZE));
                        rec_ack  = ack_mark;
                        dups     = '0;
                        halvings++;
                    end
                end
                else if (d >= 1 && d <= flight)
                begin
                    if (cwnd < ssthresh || cwnd == '0)
                        cwnd = win_add(cwnd, SEQ_W'(SEGMENT_SIZE));
                    else
                        cwnd = win_add(cwnd, SEQ_W'(SEGMENT_SIZE * SEGMENT_SIZE)
                                             / {12'd0, cwnd});
                    ack_mark = w.ack_number;
                    rec_ack  = w.ack_number;
                    dups     = '0;
                end
            end
            tcwseg_pkg::OP_TIMEOUT:
            begin
                ssthresh = cwnd >> 1;
                cwnd     = WIN_W'(SEGMENT_SIZE);
                rec_ack  = ack_mark;
                dups     = '0;
                snd_mark = ack_mark;
                rewinds++;
            end
            default:
            begin
                flight = snd_mark - ack_mark;
                unsent = headroom({16'd0, w.buffered_bytes}, flight);
                while (unsent != '0 && n < MAX_SEGMENTS)
                begin
                    used = snd_mark - ack_mark;
                    len  = unsent;
                    len  = smaller(len, headroom({16'd0, win_limit}, used));
                    len  = smaller(len, headroom({12'd0, cwnd}, used));
                    len  = smaller(len, headroom({16'd0, w.recv_window}, used));
                    len  = smaller(len, SEQ_W'(SEGMENT_SIZE));
                    if (len == '0)
                        break;
                    if (n > 0)
                        enqueue(held);
                    held = make_word(snd_mark + SEQ_W'(1), len, used, 1'b0);
                    n++;
                    snd_mark = snd_mark + len;
                    unsent   = unsent - len;
                end
                if (n > burst_max)
                    burst_max = n;
            end
        endcase
        if (n > 0)
        begin
            held.last = 1'b1;
            enqueue(held);
        end
        else
        begin
            enqueue(make_word(snd_mark + SEQ_W'(1), '0, snd_mark - ack_mark, 1'b1));
        end
    endtask

    task automatic check_word(input tcwseg_pkg::out_item_t got);
        tcwseg_pkg::out_item_t want;
        words++;
        if (due_words.size() == 0)
        begin
            report("word with nothing due", got.segment_seq, '0);
        end
        else
        begin
            want = due_words.pop_front();
            if (got.segment_seq != want.segment_seq)
                report("segment_seq", got.segment_seq, want.segment_seq);
            if (got.segment_length != want.segment_length)
                report("segment_length", SEQ_W'(got.segment_length),
                       SEQ_W'(want.segment_length));
            if (got.buffer_offset != want.buffer_offset)
                report("buffer_offset", SEQ_W'(got.buffer_offset),
                       SEQ_W'(want.buffer_offset));
            if (got.congestion_window != want.congestion_window)
                report("congestion_window", SEQ_W'(got.congestion_window),
                       SEQ_W'(want.congestion_window));
            if (got.slow_start_threshold != want.slow_start_threshold)
                report("slow_start_threshold", SEQ_W'(got.slow_start_threshold),
                       SEQ_W'(want.slow_start_threshold));
            if (got.last != want.last)
                report("last", SEQ_W'(got.last), SEQ_W'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_seq  = tcwseg_pkg::INIT_SEQ_RESET;
            win_limit = tcwseg_pkg::WIN_LIMIT_RESET;
            restart();
            due_words.delete();
            fails     = 0;
            ops       = 0;
            words     = 0;
            burst_max = 0;
            halvings  = 0;
            rewinds   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_word(out_word);
            if (in_valid && in_ready)
                advance_connection(in_word);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {tcwseg_pkg::REG_WIN_LIMIT, 2'b00})
                    win_limit = pwdata[OFF_W-1:0];
                else if (paddr == {tcwseg_pkg::REG_INIT_SEQ, 2'b00})
                    init_seq = pwdata[SEQ_W-1:0];
            end
        end
        sent_upto     <= snd_mark;
        acked_upto    <= ack_mark;
        due_count     <= due_words.size();
        fail_count    <= fails;
        op_count      <= ops;
        word_count    <= words;
        longest_burst <= burst_max;
        recoveries    <= halvings;
        timeouts      <= rewinds;
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Top of the congestion window segmenter bench. Drives operations with random
// gaps and output stalls through six register settings: a directed opening,
// a slow start ramp up to long send bursts, then random operation mixes.
// The scoreboard beside the block checks every output word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SEQ_W        = tcwseg_pkg::SEQ_W;
    localparam int OFF_W        = tcwseg_pkg::OFF_W;
    localparam int OP_W         = tcwseg_pkg::OP_W;
    localparam int APB_ADDR_W   = tcwseg_pkg::APB_ADDR_W;
    localparam int APB_DATA_W   = tcwseg_pkg::APB_DATA_W;
    localparam int SEGMENT_SIZE = 1024;
    localparam int MAX_SEGMENTS = 64;
    localparam int STALL_LIMIT  = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic [SEQ_W-1:0]      sent_upto;
    logic [SEQ_W-1:0]      acked_upto;
    int                    due_count;
    int                    fail_count;
    int                    op_count;
    int                    word_count;
    int                    longest_burst;
    int                    recoveries;
    int                    timeouts;
    bit                    calm;

    tcwseg_stream_if #(.payload_t(tcwseg_pkg::in_item_t))  in_ch ();
    tcwseg_stream_if #(.payload_t(tcwseg_pkg::out_item_t)) out_ch ();

    tcp_congestion_window_segmenter #(
        .SEGMENT_SIZE (SEGMENT_SIZE),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tcwseg_checker #(
        .SEGMENT_SIZE (SEGMENT_SIZE),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .in_word       (in_ch.payload),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_word      (out_ch.payload),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .sent_upto     (sent_upto),
        .acked_upto    (acked_upto),
        .due_count     (due_count),
        .fail_count    (fail_count),
        .op_count      (op_count),
        .word_count    (word_count),
        .longest_burst (longest_burst),
        .recoveries    (recoveries),
        .timeouts      (timeouts)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic tcwseg_pkg::in_item_t op_word(input logic [OP_W-1:0]  op,
                                                     input logic [SEQ_W-1:0] ack,
                                                     input logic [OFF_W-1:0] held_bytes,
                                                     input logic [OFF_W-1:0] rwnd);
        tcwseg_pkg::in_item_t w;
        w.operation      = op;
        w.ack_number     = ack;
        w.buffered_bytes = held_bytes;
        w.recv_window    = rwnd;
        return w;
    endfunction

    function automatic logic [OFF_W-1:0] fill_level(input logic [SEQ_W-1:0] span);
        logic [SEQ_W-1:0] total;
        if ($urandom_range(0, 7) == 0)
            return OFF_W'($urandom);
        total = span + $urandom_range(0, 6000);
        return (total > 32'hFFFF) ? 16'hFFFF : total[OFF_W-1:0];
    endfunction

    // waits past the accepting edge so the scoreboard marks are current
    task automatic issue(input tcwseg_pkg::in_item_t w);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        do @(posedge clk); while (!in_ch.ready);
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (due_count != 0)
            @(posedge clk);
    endtask

    task automatic churn(input int count);
        int               k;
        int               pick;
        logic [SEQ_W-1:0] span;
        k = 0;
        while (k < count)
        begin
            pick = $urandom_range(0, 99);
            span = sent_upto - acked_upto;
            if (pick < 35)
            begin
                issue(op_word(tcwseg_pkg::OP_SEND, $urandom, fill_level(span),
                              ($urandom_range(0, 2) != 0) ? 16'hFFFF : OFF_W'($urandom)));
                k++;
            end
            else if (pick < 60 && span != '0)
            begin
                issue(op_word(tcwseg_pkg::OP_ACK, acked_upto + $urandom_range(1, span),
                              OFF_W'($urandom), OFF_W'($urandom)));
                k++;
            end
            else if (pick < 72)
            begin
                repeat (3)
                begin
                    issue(op_word(tcwseg_pkg::OP_ACK, acked_upto, OFF_W'($urandom),
                                  OFF_W'($urandom)));
                end
                k += 3;
            end
            else if (pick < 78)
            begin
                issue(op_word(tcwseg_pkg::OP_TIMEOUT, $urandom, OFF_W'($urandom),
                              OFF_W'($urandom)));
                k++;
            end
            else if (pick < 81)
            begin
                issue(op_word(tcwseg_pkg::OP_INIT, $urandom, OFF_W'($urandom),
                              OFF_W'($urandom)));
                k++;
            end
            else if (pick < 90)
            begin
                issue(op_word(tcwseg_pkg::OP_ACK, ($urandom_range(0, 1) != 0) ?
                              sent_upto + $urandom_range(1, 4000) :
                              acked_upto - $urandom_range(1, 4000),
                              OFF_W'($urandom), OFF_W'($urandom)));
                k++;
            end
            else
            begin
                issue(op_word(OP_W'($urandom_range(0, 3)), $urandom,
                              OFF_W'($urandom), OFF_W'($urandom)));
                k++;
            end
        end
    endtask

    initial
    begin : out_pacing
        int n;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 12);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [SEQ_W-1:0] span;
        logic [SEQ_W-1:0] fill;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: short buffer, cwnd limit, stray and duplicate acks
        issue(op_word(tcwseg_pkg::OP_SEND, '0, '0, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_SEND, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_ACK, acked_upto + 32'd1, '0, '0));
        issue(op_word(tcwseg_pkg::OP_ACK, sent_upto + 32'd1, '0, '0));
        issue(op_word(tcwseg_pkg::OP_ACK, acked_upto - 32'd5, '0, '0));
        repeat (3)
        begin
            issue(op_word(tcwseg_pkg::OP_ACK, acked_upto, 16'hFFFF, 16'hFFFF));
        end
        issue(op_word(tcwseg_pkg::OP_SEND, '0, 16'hFFFF, '0));
        issue(op_word(tcwseg_pkg::OP_SEND, '0, 16'hFFFF, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_SEND, '0, OFF_W'(sent_upto - acked_upto), 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_SEND, '0, 16'hFFFF, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_ACK, sent_upto, '0, '0));
        issue(op_word(tcwseg_pkg::OP_ACK, '0, '0, '0));
        issue(op_word(tcwseg_pkg::OP_ACK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_INIT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        issue(op_word(tcwseg_pkg::OP_SEND, 32'hFFFF_FFFF, 16'h0001, 16'h0001));
        issue(op_word(tcwseg_pkg::OP_SEND, '0, 16'hFFFF, 16'h8000));
        issue(op_word(tcwseg_pkg::OP_TIMEOUT, '0, '0, '0));

        // sequence wrap, widest go-back window: slow start up to long bursts
        drain();
        write_reg(tcwseg_pkg::REG_INIT_SEQ, 32'hFFFF_FF00);
        write_reg(tcwseg_pkg::REG_WIN_LIMIT, 32'h0000_FFFF);
        issue(op_word(tcwseg_pkg::OP_INIT, '0, '0, '0));
        repeat (66)
        begin
            span = sent_upto - acked_upto;
            fill = span + $urandom_range(1, 4096);
            issue(op_word(tcwseg_pkg::OP_SEND, $urandom,
                          (fill > 32'hFFFF) ? 16'hFFFF : fill[OFF_W-1:0], 16'hFFFF));
            span = sent_upto - acked_upto;
            if (span != '0)
                issue(op_word(tcwseg_pkg::OP_ACK, acked_upto + $urandom_range(1, span),
                              OFF_W'($urandom), OFF_W'($urandom)));
        end
        if (sent_upto != acked_upto)
            issue(op_word(tcwseg_pkg::OP_ACK, sent_upto, '0, '0));
        issue(op_word(tcwseg_pkg::OP_SEND, '0, 16'hFFFF, 16'hFFFF));
        churn(28);

        // smallest go-back window, one-byte segments
        drain();
        write_reg(tcwseg_pkg::REG_INIT_SEQ, '0);
        write_reg(tcwseg_pkg::REG_WIN_LIMIT, 32'd1);
        issue(op_word(tcwseg_pkg::OP_INIT, '0, '0, '0));
        churn(30);

        // mid-size window, then lowered under the bytes in flight
        drain();
        write_reg(tcwseg_pkg::REG_INIT_SEQ, 32'hFFFF_FFFF);
        write_reg(tcwseg_pkg::REG_WIN_LIMIT, $urandom_range(2000, 20000));
        issue(op_word(tcwseg_pkg::OP_INIT, '0, '0, '0));
        churn(20);
        drain();
        write_reg(tcwseg_pkg::REG_WIN_LIMIT, $urandom_range(1, 512));
        churn(15);

        // new start sequence only takes effect at the next init
        drain();
        write_reg(tcwseg_pkg::REG_INIT_SEQ, $urandom);
        write_reg(tcwseg_pkg::REG_WIN_LIMIT, $urandom_range(1024, 65535));
        churn(15);
        issue(op_word(tcwseg_pkg::OP_INIT, '0, '0, '0));
        calm = 1'b1;
        churn(40);

        drain();
        repeat (40) @(posedge clk);
        $display("covered %0d operations and %0d words over six register settings",
                 op_count, word_count);
        $display("longest send burst %0d segments, %0d fast recoveries, %0d timeouts",
                 longest_burst, recoveries, timeouts);
        if (fail_count == 0 && due_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
